// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file mbd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, muted while reset is high
`define MBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked at every rising edge, reset included
`define MBD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== hw/rtl/mbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

   localparam int MAX_WIDTH_LOG2_DEF = 12;
   localparam int PIX_W              = 8;
   localparam int LANE_W             = 9;
   localparam int LANES              = 4;
   localparam int PACK_W             = LANES * LANE_W;
   localparam int LOG2_W             = 4;
   localparam int CSR_W              = 4;
   localparam int QUEUE_DEPTH        = 4;

   typedef enum logic [1:0] {
      CSR_WIDTH_LOG2  = 2'd0,
      CSR_HEIGHT_LOG2 = 2'd1,
      CSR_GRAY_MODE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LOG2_W-1:0] width_log2;
      logic [LOG2_W-1:0] height_log2;
      logic              gray;
   } cfg_type;

   typedef struct packed {
      logic [PACK_W-1:0] hsum;
      logic              use_store;
      logic              upper_row;
      logic [1:0]        shift;
      logic              gray;
      logic              last;
   } job_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mbd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbd_front #(
   parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEF,
   parameter int IDX_W          = (MAX_WIDTH_LOG2 > 1) ? MAX_WIDTH_LOG2 - 1 : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mbd_pkg::cfg_type           cfg,
   input  wire logic                       accept,
   input  wire logic                       first_pixel,
   input  wire logic [mbd_pkg::PIX_W-1:0]  pix_a,
   input  wire logic [mbd_pkg::PIX_W-1:0]  pix_r,
   input  wire logic [mbd_pkg::PIX_W-1:0]  pix_g,
   input  wire logic [mbd_pkg::PIX_W-1:0]  pix_b,
   output mbd_pkg::job_type                job,
   output logic                            job_valid,
   output logic [IDX_W-1:0]                job_idx
);

   localparam int STORE_DEPTH = 1 << (MAX_WIDTH_LOG2 - 1);
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(STORE_DEPTH - 1);
   localparam int LW = mbd_pkg::LANE_W;

   logic [MAX_WIDTH_LOG2-1:0] col_ff, col_in;
   logic [MAX_WIDTH_LOG2-1:0] row_ff, row_in;
   logic [mbd_pkg::PACK_W-1:0] pair_ff, pair_in;

   logic [mbd_pkg::LOG2_W-1:0] wl, hl;
   logic fx, fy;
   logic [MAX_WIDTH_LOG2-1:0] x, y, wlast, hlast, idx_full;
   logic [mbd_pkg::PACK_W-1:0] pix, lane_sum, hsum;
   logic have_h, at_wend, at_hend;

   always_comb begin
      wl = (cfg.width_log2 > mbd_pkg::LOG2_W'(MAX_WIDTH_LOG2)) ?
           mbd_pkg::LOG2_W'(MAX_WIDTH_LOG2) : cfg.width_log2;
      hl = (cfg.height_log2 > mbd_pkg::LOG2_W'(MAX_WIDTH_LOG2)) ?
           mbd_pkg::LOG2_W'(MAX_WIDTH_LOG2) : cfg.height_log2;
      fx = (wl != '0);
      fy = (hl != '0);
      for (int i = 0; i < MAX_WIDTH_LOG2; i++) begin
         wlast[i] = (mbd_pkg::LOG2_W'(i) < wl);
         hlast[i] = (mbd_pkg::LOG2_W'(i) < hl);
      end
      x = first_pixel ? '0 : col_ff;
      y = first_pixel ? '0 : row_ff;

      // lane 0 alpha, 1 red, 2 green, 3 blue
      if (cfg.gray) begin
         pix = {{(2 * LW){1'b0}}, 1'b0, pix_r, {LW{1'b0}}};
      end else begin
         pix = {1'b0, pix_b, 1'b0, pix_g, 1'b0, pix_r, 1'b0, pix_a};
      end
      for (int c = 0; c < mbd_pkg::LANES; c++) begin
         lane_sum[c*LW +: LW] = pair_ff[c*LW +: LW] + pix[c*LW +: LW];
      end

      pair_in = pair_ff;
      hsum    = pix;
      have_h  = 1'b1;
      if (fx) begin
         if (!x[0]) begin
            pair_in = pix;
            have_h  = 1'b0;
         end else begin
            pair_in = lane_sum;
            hsum    = lane_sum;
         end
      end

      idx_full = fx ? (x >> 1) : x;
      at_wend  = (x >= wlast);
      at_hend  = (y >= hlast);

      if (at_wend) begin
         col_in = '0;
         row_in = at_hend ? '0 : y + MAX_WIDTH_LOG2'(1);
      end else begin
         col_in = x + MAX_WIDTH_LOG2'(1);
         row_in = y;
      end
   end

   always_comb begin
      job_valid     = accept && have_h;
      job_idx       = idx_full[IDX_W-1:0] & IDX_MASK;
      job.hsum      = hsum;
      job.use_store = fy;
      job.upper_row = !y[0];
      job.shift     = {1'b0, fx} + {1'b0, fy};
      job.gray      = cfg.gray;
      job.last      = at_wend && at_hend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pair_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pair_ff <= pair_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mbd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbd_queue #(
   parameter int IDX_W = 11,
   parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mbd_pkg::job_type  push_job,
   input  wire logic [IDX_W-1:0]  push_idx,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output mbd_pkg::job_type       job,
   output logic [IDX_W-1:0]       idx
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbd_pkg::job_type  job_ff [DEPTH];
   logic [IDX_W-1:0]  idx_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      valid   = (count_ff != '0);
      job     = job_ff[rd_ptr_ff];
      idx     = idx_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         job_ff[wr_ptr_ff] <= push_job;
         idx_ff[wr_ptr_ff] <= push_idx;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mbd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbd_back #(
   parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEF,
   parameter int IDX_W          = (MAX_WIDTH_LOG2 > 1) ? MAX_WIDTH_LOG2 - 1 : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_valid,
   input  wire mbd_pkg::job_type          q_job,
   input  wire logic [IDX_W-1:0]          q_idx,
   output logic                           q_pop,
   input  wire logic                      rsp_pop,
   output logic                           rsp_empty,
   output logic [mbd_pkg::PIX_W-1:0]      rsp_out_a,
   output logic [mbd_pkg::PIX_W-1:0]      rsp_out_r,
   output logic [mbd_pkg::PIX_W-1:0]      rsp_out_g,
   output logic [mbd_pkg::PIX_W-1:0]      rsp_out_b,
   output logic                           rsp_out_last
);

   localparam int STORE_DEPTH = 1 << (MAX_WIDTH_LOG2 - 1);
   localparam int LW = mbd_pkg::LANE_W;
   localparam int PW = mbd_pkg::PIX_W;

   // upper-row pair sums (plain pixels when width log2 is 0), one entry per destination column
   logic [mbd_pkg::PACK_W-1:0] store_mem [STORE_DEPTH];
   logic [mbd_pkg::PACK_W-1:0] rd_ff;

   logic             s1_valid_ff;
   mbd_pkg::job_type s1_job_ff;
   logic             out_valid_ff;
   logic [PW-1:0]    out_a_ff, out_r_ff, out_g_ff, out_b_ff;
   logic             out_last_ff;

   logic s1_emit, s1_adv, s1_free, out_free;
   logic [mbd_pkg::LANES-1:0][LW:0]   total;
   logic [mbd_pkg::LANES-1:0][PW-1:0] avg;

   always_comb begin
      out_free = !out_valid_ff || rsp_pop;
      s1_emit  = !(s1_job_ff.use_store && s1_job_ff.upper_row);
      s1_adv   = s1_valid_ff && (!s1_emit || out_free);
      s1_free  = !s1_valid_ff || s1_adv;
      q_pop    = q_valid && s1_free;
      for (int c = 0; c < mbd_pkg::LANES; c++) begin
         total[c] = {1'b0, s1_job_ff.hsum[c*LW +: LW]} +
                    (s1_job_ff.use_store ? {1'b0, rd_ff[c*LW +: LW]} : '0);
         avg[c]   = PW'(total[c] >> s1_job_ff.shift);
      end
   end

   // line store write on upper rows, read on lower rows
   always_ff @(posedge clock) begin
      if (q_pop && q_job.use_store) begin
         if (q_job.upper_row) begin
            store_mem[q_idx] <= q_job.hsum;
         end else begin
            rd_ff <= store_mem[q_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= q_valid;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff && s1_emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_job_ff <= q_job;
      end
      if (out_free && s1_valid_ff && s1_emit) begin
         out_a_ff    <= s1_job_ff.gray ? '0 : avg[0];
         out_r_ff    <= avg[1];
         out_g_ff    <= s1_job_ff.gray ? '0 : avg[2];
         out_b_ff    <= s1_job_ff.gray ? '0 : avg[3];
         out_last_ff <= s1_job_ff.last;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_a    = out_a_ff;
   assign rsp_out_r    = out_r_ff;
   assign rsp_out_g    = out_g_ff;
   assign rsp_out_b    = out_b_ff;
   assign rsp_out_last = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mip_box_downsample.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a result shows on the rsp ports once the pixel that ends its box has passed the job queue, s1 and output registers
// throughput: one source pixel per clock while req_full is low, set by the single-port line store and one add per stage
// a 4-entry job queue lets pixel intake run on while results are held back by rsp_pop
// reset (synchronous, active high): position counters, pair sum, queue and output cleared,
// registers back to width log2 1, height log2 1, argb mode; line store is not cleared

module mip_box_downsample #(
   parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [mbd_pkg::CSR_W-1:0]  csr_wdata,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic                       req_first_pixel,
   input  wire logic [mbd_pkg::PIX_W-1:0]  req_pix_a,
   input  wire logic [mbd_pkg::PIX_W-1:0]  req_pix_r,
   input  wire logic [mbd_pkg::PIX_W-1:0]  req_pix_g,
   input  wire logic [mbd_pkg::PIX_W-1:0]  req_pix_b,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [mbd_pkg::PIX_W-1:0]       rsp_out_a,
   output logic [mbd_pkg::PIX_W-1:0]       rsp_out_r,
   output logic [mbd_pkg::PIX_W-1:0]       rsp_out_g,
   output logic [mbd_pkg::PIX_W-1:0]       rsp_out_b,
   output logic                            rsp_out_last
);

   localparam int IDX_W = (MAX_WIDTH_LOG2 > 1) ? MAX_WIDTH_LOG2 - 1 : 1;

   mbd_pkg::cfg_type cfg_ff;
   mbd_pkg::job_type f_job, q_job;
   logic [IDX_W-1:0] f_idx, q_idx;
   logic             f_valid, q_valid, q_pop, q_full, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_log2  <= mbd_pkg::LOG2_W'(1);
         cfg_ff.height_log2 <= mbd_pkg::LOG2_W'(1);
         cfg_ff.gray        <= 1'b0;
      end else if (csr_wr_en) begin
         case (mbd_pkg::csr_index_type'(csr_index))
            mbd_pkg::CSR_WIDTH_LOG2: begin
               cfg_ff.width_log2 <= csr_wdata;
            end
            mbd_pkg::CSR_HEIGHT_LOG2: begin
               cfg_ff.height_log2 <= csr_wdata;
            end
            mbd_pkg::CSR_GRAY_MODE: begin
               cfg_ff.gray <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   mbd_front #(
      .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
      .IDX_W          (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .first_pixel (req_first_pixel),
      .pix_a       (req_pix_a),
      .pix_r       (req_pix_r),
      .pix_g       (req_pix_g),
      .pix_b       (req_pix_b),
      .job         (f_job),
      .job_valid   (f_valid),
      .job_idx     (f_idx)
   );

   mbd_queue #(
      .IDX_W (IDX_W),
      .DEPTH (mbd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_job (f_job),
      .push_idx (f_idx),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .job      (q_job),
      .idx      (q_idx)
   );

   mbd_back #(
      .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
      .IDX_W          (IDX_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_job        (q_job),
      .q_idx        (q_idx),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_a    (rsp_out_a),
      .rsp_out_r    (rsp_out_r),
      .rsp_out_g    (rsp_out_g),
      .rsp_out_b    (rsp_out_b),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mbd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbd_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_full,
   input wire logic                      rsp_empty,
   input wire logic                      rsp_pop,
   input wire logic [mbd_pkg::PIX_W-1:0] rsp_out_a,
   input wire logic [mbd_pkg::PIX_W-1:0] rsp_out_r,
   input wire logic [mbd_pkg::PIX_W-1:0] rsp_out_g,
   input wire logic [mbd_pkg::PIX_W-1:0] rsp_out_b,
   input wire logic                      rsp_out_last
);

   logic [4*mbd_pkg::PIX_W:0] rsp_word;

   assign rsp_word = {rsp_out_a, rsp_out_r, rsp_out_g, rsp_out_b, rsp_out_last};

   property p_rsp_hold;
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word));
   endproperty

   // no result survives reset
   `MBD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "result visible after reset")

   // the job queue comes out of reset with room
   `MBD_ASSERT_ALWAYS(a_reset_room, clock, reset |=> !req_full, "input full after reset")

   // a waiting result holds until its transfer
   `MBD_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "waiting result changed")

endmodule

bind mip_box_downsample mbd_checker u_mbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_a    (rsp_out_a),
   .rsp_out_r    (rsp_out_r),
   .rsp_out_g    (rsp_out_g),
   .rsp_out_b    (rsp_out_b),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire
